/* src/pfr_pkg.sv */
// Shared constants, status codes and queue entry type for the page frame replacer.
// No dependencies; every other file imports this package.
package pfr_pkg;

  localparam int FRAMES      = 8;
  localparam int SWAP_SLOTS  = 16;
  localparam int PROCESSES   = 16;
  localparam int QUEUE_DEPTH = 2;

  localparam int PID_W       = 5;
  localparam int PAGE_W      = 5;
  localparam int STAMP_W     = 32;
  localparam int STATUS_W    = 3;
  localparam int FRAME_IDX_W = 3;
  localparam int SLOT_W      = 4;

  localparam int FRAME_W = (FRAMES > 1) ? $clog2(FRAMES) : 1;
  localparam int SWAP_W  = $clog2(SWAP_SLOTS + 1);
  localparam int NPAIR   = (FRAMES + 1) / 2;
  localparam int QPTR_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W  = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [STATUS_W-1:0] {
    ST_HIT      = 3'd0,
    ST_FREE     = 3'd1,
    ST_EVICT    = 3'd2,
    ST_BADPID   = 3'd3,
    ST_SWAPFULL = 3'd4
  } status_t;

  // One classified reference waiting for the back end.
  typedef struct packed {
    logic               bad;
    logic [PID_W-1:0]   pid;
    logic [PAGE_W-1:0]  page;
    logic [STAMP_W-1:0] stamp;
  } ref_t;

endpackage

/* src/pfr_if.sv */
// Handshake channels of the page frame replacer: references in, results out, config.
// Depends on pfr_pkg for field widths.
interface pfr_req_if import pfr_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [PID_W-1:0]  process_id;
  logic [PAGE_W-1:0] page_number;

  modport source (output valid, output process_id, output page_number, input ready);
  modport sink   (input valid, input process_id, input page_number, output ready);
endinterface

interface pfr_res_if import pfr_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic [STATUS_W-1:0]    status;
  logic [FRAME_IDX_W-1:0] frame_index;
  logic [PID_W-1:0]       victim_process;
  logic [PAGE_W-1:0]      victim_page;
  logic [SLOT_W-1:0]      swap_slot;

  modport source (output valid, output status, output frame_index, output victim_process,
                  output victim_page, output swap_slot, input ready);
  modport sink   (input valid, input status, input frame_index, input victim_process,
                  input victim_page, input swap_slot, output ready);
endinterface

interface pfr_cfg_if ();
  logic valid;
  logic ready;
  logic policy_mode;

  modport source (output valid, output policy_mode, input ready);
  modport sink   (input valid, input policy_mode, output ready);
endinterface

/* src/pfr_queue.sv */
// Short queue of classified references between front and back end.
// Depends on pfr_pkg (ref_t, QUEUE_DEPTH).
module pfr_queue import pfr_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  ref_t              push_data,
  output logic              not_full,
  output ref_t              head,
  output logic              head_valid,
  input  logic              pop,
  output logic [QCNT_W-1:0] count
);

  ref_t              slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;

  function automatic logic [QPTR_W-1:0] bump(input logic [QPTR_W-1:0] p);
    if (p == QPTR_W'(QUEUE_DEPTH - 1)) begin
      return '0;
    end
    return p + 1'b1;
  endfunction

  assign not_full   = (count != QCNT_W'(QUEUE_DEPTH));
  assign head_valid = (count != '0);
  assign head       = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= bump(wr_ptr);
      end
      if (pop) begin
        rd_ptr <= bump(rd_ptr);
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

/* src/pfr_front.sv */
// Front end: accepts references, checks the process id and stamps each one.
// Depends on pfr_pkg and pfr_req_if.
module pfr_front import pfr_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  pfr_req_if.sink   req,
  input  logic      q_not_full,
  output logic      push,
  output ref_t      push_data
);

  logic [STAMP_W-1:0] access_clock;
  logic [STAMP_W-1:0] access_clock_next;

  assign req.ready         = q_not_full;
  assign push              = req.valid && q_not_full;
  assign access_clock_next = access_clock + 1'b1;

  // Id 0 and ids above the process count are rejected later without touching the table.
  always_comb begin
    push_data.bad   = (req.process_id == '0) ||
                      (req.process_id > PID_W'(PROCESSES));
    push_data.pid   = req.process_id;
    push_data.page  = req.page_number;
    push_data.stamp = access_clock_next;
  end

  // Advance the clock on every transfer, rejected ones included.
  always_ff @(posedge clk) begin
    if (rst) begin
      access_clock <= '0;
    end else if (push) begin
      access_clock <= access_clock_next;
    end
  end

endmodule

/* src/pfr_back.sv */
// Back end: frame table, hit lookup, victim search, table update and result register.
// Depends on pfr_pkg and pfr_res_if.
module pfr_back import pfr_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      policy_mode,
  input  ref_t      head,
  input  logic      head_valid,
  output logic      head_pop,
  pfr_res_if.source res
);

  typedef enum logic {S_LOOK, S_WRITE} state_t;

  state_t             state;
  logic [PID_W-1:0]   frame_owner [FRAMES];
  logic [PAGE_W-1:0]  frame_page  [FRAMES];
  logic [STAMP_W-1:0] frame_stamp [FRAMES];
  logic [FRAMES-1:0]  frame_valid;
  logic [FRAME_W-1:0] placement_pointer;
  logic               frames_full;
  logic [SWAP_W-1:0]  swap_used;

  logic               hit;
  logic [FRAME_W-1:0] hit_idx;
  logic [FRAME_W-1:0] pair_idx   [NPAIR];
  logic [STAMP_W-1:0] pair_stamp [NPAIR];

  logic               hit_next;
  logic [FRAME_W-1:0] hit_idx_next;
  logic [FRAME_W-1:0] pair_idx_next   [NPAIR];
  logic [STAMP_W-1:0] pair_stamp_next [NPAIR];
  logic [FRAME_W-1:0] lru_idx;
  logic [STAMP_W-1:0] lru_stamp;
  logic [FRAME_W-1:0] place_idx;
  logic [FRAME_W-1:0] pointer_next;
  logic               out_free;
  logic               swap_full;

  // Lowest matching frame wins.
  always_comb begin
    hit_next     = 1'b0;
    hit_idx_next = '0;
    for (int k = FRAMES - 1; k >= 0; k--) begin
      if (frame_valid[k] && frame_owner[k] == head.pid && frame_page[k] == head.page) begin
        hit_next     = 1'b1;
        hit_idx_next = FRAME_W'(k);
      end
    end
  end

  // First level of the oldest-stamp search: one compare per frame pair, lower index on ties.
  for (genvar j = 0; j < NPAIR; j++) begin : g_pair
    if (2 * j + 1 < FRAMES) begin : g_two
      always_comb begin
        if (frame_stamp[2*j+1] < frame_stamp[2*j]) begin
          pair_idx_next[j]   = FRAME_W'(2 * j + 1);
          pair_stamp_next[j] = frame_stamp[2*j+1];
        end else begin
          pair_idx_next[j]   = FRAME_W'(2 * j);
          pair_stamp_next[j] = frame_stamp[2*j];
        end
      end
    end else begin : g_one
      assign pair_idx_next[j]   = FRAME_W'(2 * j);
      assign pair_stamp_next[j] = frame_stamp[2*j];
    end
  end

  // Finish the search over the registered pair winners.
  always_comb begin
    lru_idx   = pair_idx[0];
    lru_stamp = pair_stamp[0];
    for (int j = 1; j < NPAIR; j++) begin
      if (pair_stamp[j] < lru_stamp) begin
        lru_idx   = pair_idx[j];
        lru_stamp = pair_stamp[j];
      end
    end
  end

  assign place_idx    = (frames_full && policy_mode) ? lru_idx : placement_pointer;
  assign pointer_next = (placement_pointer == FRAME_W'(FRAMES - 1)) ? '0
                                                                    : placement_pointer + 1'b1;
  assign swap_full    = frames_full && (swap_used >= SWAP_W'(SWAP_SLOTS));
  assign out_free     = !res.valid || res.ready;
  assign head_pop     = (state == S_WRITE) && out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      state             <= S_LOOK;
      frame_valid       <= '0;
      placement_pointer <= '0;
      frames_full       <= 1'b0;
      swap_used         <= '0;
      res.valid         <= 1'b0;
    end else begin
      if (res.valid && res.ready) begin
        res.valid <= 1'b0;
      end
      unique case (state)
        S_LOOK: begin
          if (head_valid) begin
            hit     <= hit_next;
            hit_idx <= hit_idx_next;
            for (int j = 0; j < NPAIR; j++) begin
              pair_idx[j]   <= pair_idx_next[j];
              pair_stamp[j] <= pair_stamp_next[j];
            end
            state <= S_WRITE;
          end
        end
        S_WRITE: begin
          if (out_free) begin
            res.valid          <= 1'b1;
            res.frame_index    <= '0;
            res.victim_process <= '0;
            res.victim_page    <= '0;
            res.swap_slot      <= '0;
            priority if (head.bad) begin
              res.status <= ST_BADPID;
            end else if (hit) begin
              res.status           <= ST_HIT;
              res.frame_index      <= FRAME_IDX_W'(hit_idx);
              frame_stamp[hit_idx] <= head.stamp;
            end else if (swap_full) begin
              res.status <= ST_SWAPFULL;
            end else begin
              res.frame_index <= FRAME_IDX_W'(place_idx);
              if (frames_full) begin
                res.status         <= ST_EVICT;
                res.victim_process <= frame_owner[place_idx];
                res.victim_page    <= frame_page[place_idx];
                res.swap_slot      <= SLOT_W'(swap_used);
                swap_used          <= swap_used + 1'b1;
              end else begin
                res.status <= ST_FREE;
              end
              frame_owner[place_idx] <= head.pid;
              frame_page[place_idx]  <= head.page;
              frame_stamp[place_idx] <= head.stamp;
              frame_valid[place_idx] <= 1'b1;
              placement_pointer      <= pointer_next;
              if (pointer_next == '0) begin
                frames_full <= 1'b1;
              end
            end
            state <= S_LOOK;
          end
        end
        default: state <= S_LOOK;
      endcase
    end
  end

endmodule

/* src/page_frame_replacer_fifo_lru.sv */
// Top level of the page frame replacer: config register, front end, queue, back end.
// Depends on pfr_pkg, pfr_if, pfr_front, pfr_queue and pfr_back.
//
// Usage:
//   req carries one page reference per transfer (process_id, page_number).
//   res returns exactly one result per reference, in order: status, the frame
//   that holds the page, and the victim and swap slot when a page was evicted.
//   cfg writes policy_mode (0 round-robin, 1 least recently used); write it
//   only while no reference is in flight. cfg is always ready.
// Operation:
//   The front end stamps and classifies a reference in the cycle it transfers
//   and drops it into a two-entry queue. The back end takes each reference
//   through a lookup state (hit compare over all frames, first level of the
//   oldest-stamp search) and then an update state (search finish, table
//   write, result load), and starts the next lookup only after the update.
// Reset (rst, synchronous): clears the frame table valid bits, placement
//   pointer, swap count, access clock, queue and result register; policy_mode
//   returns to round-robin. No clearing pass is needed.
// Stall: while res is held the result register keeps its value, the back end
//   waits in its update state and the queue fills; req drops ready when full.
module page_frame_replacer_fifo_lru import pfr_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  pfr_req_if.sink  req,
  pfr_res_if.source res,
  pfr_cfg_if.sink  cfg
);

  logic              policy_mode;
  logic              push;
  ref_t              push_data;
  logic              q_not_full;
  ref_t              head;
  logic              head_valid;
  logic              head_pop;
  logic [QCNT_W-1:0] q_count;

  // Config transfers are taken in any cycle.
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      policy_mode <= 1'b0;
    end else if (cfg.valid) begin
      policy_mode <= cfg.policy_mode;
    end
  end

  pfr_front u_front (
    .clk        (clk),
    .rst        (rst),
    .req        (req),
    .q_not_full (q_not_full),
    .push       (push),
    .push_data  (push_data)
  );

  pfr_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_data  (push_data),
    .not_full   (q_not_full),
    .head       (head),
    .head_valid (head_valid),
    .pop        (head_pop),
    .count      (q_count)
  );

  pfr_back u_back (
    .clk         (clk),
    .rst         (rst),
    .policy_mode (policy_mode),
    .head        (head),
    .head_valid  (head_valid),
    .head_pop    (head_pop),
    .res         (res)
  );

`ifndef SYNTH
  a_queue_bound: assert property (@(posedge clk) disable iff (rst)
    q_count <= QCNT_W'(QUEUE_DEPTH))
    else $error("reference queue over capacity");

  a_pop_needs_entry: assert property (@(posedge clk) disable iff (rst)
    head_pop |-> head_valid)
    else $error("back end popped an empty queue");

  a_reject_zero: assert property (@(posedge clk) disable iff (rst)
    res.valid && (res.status == ST_BADPID || res.status == ST_SWAPFULL) |->
      res.frame_index == '0 && res.victim_process == '0 && res.victim_page == '0)
    else $error("rejected reference carries nonzero fields");

  a_no_victim: assert property (@(posedge clk) disable iff (rst)
    res.valid && (res.status == ST_HIT || res.status == ST_FREE) |->
      res.victim_process == '0 && res.swap_slot == '0)
    else $error("victim reported without eviction");
`endif

endmodule

/* verif/pfr_checker.sv */
// Scoreboard for the page frame replacer: watches req, res and cfg transfers.
// Predicts each result from its own copy of the frame table and compares it in order.
// Depends on pfr_pkg and the channel interfaces in pfr_if.
module pfr_checker import pfr_pkg::*; (
  input  logic clk,
  input  logic rst,
  pfr_req_if   req,
  pfr_res_if   res,
  pfr_cfg_if   cfg,
  output int   mismatches,
  output int   awaiting,
  output int   hits_seen,
  output int   placed_seen,
  output int   evicted_seen,
  output int   badpid_seen,
  output int   swapfull_seen
);

  typedef struct packed {
    status_t                status;
    logic [FRAME_IDX_W-1:0] frame;
    logic [PID_W-1:0]       vproc;
    logic [PAGE_W-1:0]      vpage;
    logic [SLOT_W-1:0]      slot;
  } outcome_t;

  logic [PID_W-1:0]   owner_tbl [FRAMES];
  logic [PAGE_W-1:0]  page_tbl  [FRAMES];
  logic               used_tbl  [FRAMES];
  logic [STAMP_W-1:0] stamp_tbl [FRAMES];
  logic [STAMP_W-1:0] use_clock;
  int                 place_ptr;
  logic               table_full;
  int                 swap_fill;
  logic               lru_mode;
  outcome_t           pending_outcomes [$];

  // Walk one page reference through the frame table and return its outcome.
  function automatic outcome_t resolve_reference(logic [PID_W-1:0] pid,
                                                 logic [PAGE_W-1:0] page);
    outcome_t o;
    logic     found;
    int       victim;
    o.status = ST_BADPID;
    o.frame  = '0;
    o.vproc  = '0;
    o.vpage  = '0;
    o.slot   = '0;
    found    = 1'b0;
    use_clock = use_clock + 1'b1;
    if (pid != '0 && pid <= PID_W'(PROCESSES)) begin
      for (int k = 0; k < FRAMES; k++) begin
        if (!found && used_tbl[k] && owner_tbl[k] == pid && page_tbl[k] == page) begin
          found        = 1'b1;
          stamp_tbl[k] = use_clock;
          o.frame      = FRAME_IDX_W'(k);
        end
      end
      if (found) begin
        o.status = ST_HIT;
      end else if (table_full && swap_fill >= SWAP_SLOTS) begin
        o.status = ST_SWAPFULL;
      end else begin
        victim = place_ptr;
        if (table_full) begin
          if (lru_mode) begin
            // oldest stamp wins, lowest index on a tie
            victim = 0;
            for (int k = 1; k < FRAMES; k++)
              if (stamp_tbl[k] < stamp_tbl[victim]) victim = k;
          end
          o.vproc   = owner_tbl[victim];
          o.vpage   = page_tbl[victim];
          o.slot    = SLOT_W'(swap_fill);
          swap_fill = swap_fill + 1;
          o.status  = ST_EVICT;
        end else begin
          o.status = ST_FREE;
        end
        o.frame           = FRAME_IDX_W'(victim);
        owner_tbl[victim] = pid;
        page_tbl[victim]  = page;
        used_tbl[victim]  = 1'b1;
        stamp_tbl[victim] = use_clock;
        place_ptr         = (place_ptr + 1) % FRAMES;
        if (place_ptr == 0) table_full = 1'b1;
      end
    end
    return o;
  endfunction

  function automatic void check_field(string name, int want, int got);
    if (want != got) begin
      $error("pfr_checker: %s expected %0d, got %0d", name, want, got);
      mismatches = mismatches + 1;
    end
  endfunction

  always @(posedge clk) begin
    outcome_t want;
    if (rst) begin
      for (int k = 0; k < FRAMES; k++) begin
        owner_tbl[k] = '0;
        page_tbl[k]  = '0;
        used_tbl[k]  = 1'b0;
        stamp_tbl[k] = '0;
      end
      use_clock     = '0;
      place_ptr     = 0;
      table_full    = 1'b0;
      swap_fill     = 0;
      lru_mode      = 1'b0;
      mismatches    = 0;
      hits_seen     = 0;
      placed_seen   = 0;
      evicted_seen  = 0;
      badpid_seen   = 0;
      swapfull_seen = 0;
      pending_outcomes.delete();
    end else begin
      if (res.valid && res.ready) begin
        if (pending_outcomes.size() == 0) begin
          $error("pfr_checker: result with no reference outstanding (status %0d)",
                 res.status);
          mismatches = mismatches + 1;
        end else begin
          want = pending_outcomes.pop_front();
          check_field("status", int'(want.status), int'(res.status));
          check_field("frame_index", int'(want.frame), int'(res.frame_index));
          check_field("victim_process", int'(want.vproc), int'(res.victim_process));
          check_field("victim_page", int'(want.vpage), int'(res.victim_page));
          check_field("swap_slot", int'(want.slot), int'(res.swap_slot));
          case (want.status)
            ST_HIT:    hits_seen     = hits_seen + 1;
            ST_FREE:   placed_seen   = placed_seen + 1;
            ST_EVICT:  evicted_seen  = evicted_seen + 1;
            ST_BADPID: badpid_seen   = badpid_seen + 1;
            default:   swapfull_seen = swapfull_seen + 1;
          endcase
        end
      end
      if (cfg.valid && cfg.ready) lru_mode = cfg.policy_mode;
      if (req.valid && req.ready)
        pending_outcomes.push_back(resolve_reference(req.process_id, req.page_number));
    end
    awaiting <= pending_outcomes.size();
  end

endmodule

/* verif/tb.sv */
// Top of the page frame replacer testbench: clock, reset, stimulus and verdict.
// Depends on pfr_pkg, pfr_if, page_frame_replacer_fifo_lru and pfr_checker.
module tb;
  import pfr_pkg::*;

  logic clk = 1'b0;
  logic rst = 1'b1;

  pfr_req_if req ();
  pfr_res_if res ();
  pfr_cfg_if cfg ();

  int mismatches;
  int awaiting;
  int hits_seen, placed_seen, evicted_seen, badpid_seen, swapfull_seen;
  int gap_pct   = 0;   // chance in a hundred that the sender idles a cycle
  int stall_pct = 0;   // chance in a hundred that the receiver holds off a cycle
  int policy_writes = 0;

  page_frame_replacer_fifo_lru i_dut (
    .clk (clk),
    .rst (rst),
    .req (req),
    .res (res),
    .cfg (cfg)
  );

  pfr_checker i_checker (
    .clk           (clk),
    .rst           (rst),
    .req           (req),
    .res           (res),
    .cfg           (cfg),
    .mismatches    (mismatches),
    .awaiting      (awaiting),
    .hits_seen     (hits_seen),
    .placed_seen   (placed_seen),
    .evicted_seen  (evicted_seen),
    .badpid_seen   (badpid_seen),
    .swapfull_seen (swapfull_seen)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Receiver side: one ready decision per edge, stalling at stall_pct.
  always @(posedge clk) begin
    res.ready <= (stall_pct == 0) || ($urandom_range(99) >= stall_pct);
  end

  // Hold one reference on req until it transfers. Valid stays high on return so
  // back-to-back references never lower and raise it within one step.
  task automatic send_ref(input logic [PID_W-1:0] pid, input logic [PAGE_W-1:0] page);
    if (gap_pct != 0) begin
      while ($urandom_range(99) < gap_pct) begin
        req.valid <= 1'b0;
        @(posedge clk);
      end
    end
    req.valid       <= 1'b1;
    req.process_id  <= pid;
    req.page_number <= page;
    do @(posedge clk); while (!req.ready);
  endtask

  // Drop valid and wait until every predicted result has come back, then let
  // the pipeline sit idle.
  task automatic settle();
    req.valid <= 1'b0;
    do @(posedge clk); while (awaiting != 0);
    repeat (4) @(posedge clk);
  endtask

  // Write policy_mode; only called with nothing in flight.
  task automatic write_policy(input logic mode);
    cfg.valid       <= 1'b1;
    cfg.policy_mode <= mode;
    do @(posedge clk); while (!cfg.ready);
    cfg.valid     <= 1'b0;
    policy_writes = policy_writes + 1;
  endtask

  // Random references: mostly a small working set so that hits and evictions
  // mix, the rest out-of-set misses, bad pids and fully random field values.
  task automatic run_phase(input int items, input logic mode, input int gap, input int stall);
    logic [PID_W-1:0]  pool_pid  [10];
    logic [PAGE_W-1:0] pool_page [10];
    int pick;
    int entry;
    settle();
    write_policy(mode);
    gap_pct   = gap;
    stall_pct = stall;
    for (int n = 0; n < 10; n++) begin
      pool_pid[n]  = PID_W'($urandom_range(1, PROCESSES));
      pool_page[n] = PAGE_W'($urandom_range(1, 16));
    end
    repeat (items) begin
      pick = $urandom_range(99);
      if (pick < 80) begin
        entry = $urandom_range(9);
        send_ref(pool_pid[entry], pool_page[entry]);
      end else if (pick < 88) begin
        send_ref(PID_W'($urandom_range(1, PROCESSES)), PAGE_W'($urandom_range(31)));
      end else if (pick < 96) begin
        send_ref($urandom_range(1) ? PID_W'(0) : PID_W'($urandom_range(PROCESSES + 1, 31)),
                 PAGE_W'($urandom_range(31)));
      end else begin
        send_ref(PID_W'($urandom_range(31)), PAGE_W'($urandom_range(31)));
      end
      // drift the working set now and then so misses keep coming
      if ($urandom_range(19) == 0) begin
        entry = $urandom_range(9);
        pool_pid[entry]  = PID_W'($urandom_range(1, PROCESSES));
        pool_page[entry] = PAGE_W'($urandom_range(1, 16));
      end
    end
  endtask

  initial begin
    req.valid       <= 1'b0;
    req.process_id  <= '0;
    req.page_number <= '0;
    cfg.valid       <= 1'b0;
    cfg.policy_mode <= 1'b0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Directed part, round-robin first.
    write_policy(1'b0);
    send_ref(5'd0, 5'd5);      // pid zero is rejected
    send_ref(5'd31, 5'd31);    // top pid, top page
    send_ref(5'd17, 5'd1);     // first pid past the process range
    // fill all eight frames in order; out-of-range pages are stored as given
    send_ref(5'd1, 5'd1);
    send_ref(5'd16, 5'd16);
    send_ref(5'd2, 5'd0);
    send_ref(5'd3, 5'd31);
    send_ref(5'd4, 5'd7);
    send_ref(5'd5, 5'd8);
    send_ref(5'd6, 5'd9);
    send_ref(5'd16, 5'd1);     // same page number, other process: still a miss
    send_ref(5'd3, 5'd31);     // hit
    send_ref(5'd1, 5'd1);      // hit on frame zero
    send_ref(5'd7, 5'd2);      // table full: round-robin eviction of frame zero
    send_ref(5'd7, 5'd3);
    send_ref(5'd1, 5'd1);      // its page was just evicted, so evict again
    send_ref(5'd7, 5'd2);      // hit on a refilled frame

    // Pause until the table is quiet, then switch to least recently used.
    settle();
    write_policy(1'b1);
    send_ref(5'd4, 5'd7);      // refresh two stamps to reorder the ages
    send_ref(5'd5, 5'd8);
    send_ref(5'd9, 5'd4);      // evict the oldest stamp
    send_ref(5'd9, 5'd5);
    send_ref(5'd3, 5'd31);
    send_ref(5'd16, 5'd16);

    // Random part: one phase per idling profile, policy toggled between them.
    run_phase(60, 1'b1, 0, 0);
    run_phase(200, 1'b0, 78, 0);
    run_phase(220, 1'b1, 0, 78);
    run_phase(200, 1'b0, 29, 29);

    settle();
    repeat (8) @(posedge clk);
    $display("tb: %0d references checked: %0d hits, %0d free placements, %0d evictions,",
             hits_seen + placed_seen + evicted_seen + badpid_seen + swapfull_seen,
             hits_seen, placed_seen, evicted_seen);
    $display("tb: %0d bad pid, %0d swap full, %0d policy writes over four idling profiles",
             badpid_seen, swapfull_seen, policy_writes);
    if (mismatches == 0 && awaiting == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

  // Hang guard, far beyond the slowest legal run.
  initial begin
    #(12 * 400000);
    $display("tb: FAIL");
    $finish;
  end

endmodule

/* files.f */
src/pfr_pkg.sv
src/pfr_if.sv
src/pfr_queue.sv
src/pfr_front.sv
src/pfr_back.sv
src/page_frame_replacer_fifo_lru.sv
verif/pfr_checker.sv
verif/tb.sv
